// File: hdl/brb_pkg.sv
// Shared types and constants for the byte ring buffer.
// No dependencies; imported by brb_ram and byte_ring_buffer_unit.
package brb_pkg;

  localparam int unsigned LenW     = 4;   // width of length and read_count
  localparam int unsigned DataW    = 64;  // width of packed byte fields
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ByteIdxW = 3;   // selects one byte of a packed field

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } brb_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DONE
  } brb_state_e;

endpackage

// File: hdl/byte_ring_buffer_unit.sv
// Byte ring buffer top level: control, index registers and result register.
// Depends on brb_pkg and brb_ram (the byte store).
//
// Usage: one input channel (in_valid_i/in_ready_o) carries items: a write
// chunk (opcode 0) of up to CHUNK_BYTES packed bytes, or a read request
// (opcode 1) for up to that many bytes. Lengths above CHUNK_BYTES saturate.
// Every item gives exactly one result beat on the output channel
// (out_valid_o/out_ready_i): write_accepted for writes, read_count and
// read_bytes for reads. A write that does not fit in the free space
// (STORE_BYTES - 1 minus occupancy) is refused whole.
// The store is a single byte-wide RAM, moved one byte per cycle. A stored
// write moves len bytes into the store and a read moves len bytes out, where
// len is after saturation and, for reads, clamping to the occupancy; an item
// that moves no byte (refused or zero-length write, empty or zero-length read)
// goes straight to its result. The result beat goes valid in the same cycle
// that the next item can be accepted. One item is in flight at a time;
// in_ready_o is high only between items.
// The result sits in an output register, so a stalled receiver does not hold
// the input: the next item is taken and worked on, and only its own result
// waits until the previous beat leaves.
// Reset clears both indexes (buffer empty) and the output valid; the byte
// store is not cleared and needs no sweep, since only written bytes are read.
module byte_ring_buffer_unit #(
  parameter int unsigned STORE_BYTES = 256,
  parameter int unsigned CHUNK_BYTES = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic [brb_pkg::LenW-1:0]  length_i,
  input  logic [brb_pkg::DataW-1:0] write_bytes_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      write_accepted_o,
  output logic [brb_pkg::LenW-1:0]  read_count_o,
  output logic [brb_pkg::DataW-1:0] read_bytes_o
);
  import brb_pkg::*;

  localparam int unsigned IdxW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned CntW = ((IdxW > LenW) ? IdxW : LenW) + 1;

  brb_state_e state_q, state_d;

  logic [IdxW-1:0]  ridx_q, ridx_d;
  logic [IdxW-1:0]  widx_q, widx_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [LenW-1:0]  k_q, k_d;
  logic [DataW-1:0] wdata_q, wdata_d;
  logic [DataW-1:0] rdata_q;
  logic             acc_q, acc_d;
  logic             rd_pend_q;
  logic [ByteIdxW-1:0] rd_pos_q;

  logic             out_valid_q, out_valid_d;
  logic             out_acc_q;
  logic [LenW-1:0]  out_cnt_q;
  logic [DataW-1:0] out_data_q;
  logic             out_load;

  logic             mem_we, mem_re;
  logic [ByteW-1:0] mem_rdata;

  logic [LenW-1:0]  len_sat;
  logic [CntW-1:0]  w_ext, r_ext, occ, free_space, len_ext;
  logic             fits;
  logic [LenW-1:0]  rd_n;
  logic             in_fire;

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] idx);
    return (idx == IdxW'(STORE_BYTES - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign len_sat    = (length_i > LenW'(CHUNK_BYTES)) ? LenW'(CHUNK_BYTES) : length_i;
  assign w_ext      = CntW'(widx_q);
  assign r_ext      = CntW'(ridx_q);
  assign occ        = (w_ext >= r_ext) ? (w_ext - r_ext)
                                       : (w_ext + CntW'(STORE_BYTES) - r_ext);
  assign free_space = CntW'(STORE_BYTES - 1) - occ;
  assign len_ext    = CntW'(len_sat);
  assign fits       = (len_ext <= free_space);
  assign rd_n       = (len_ext < occ) ? len_sat : occ[LenW-1:0];

  assign out_load   = (state_q == ST_DONE) && !rd_pend_q && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    ridx_d      = ridx_q;
    widx_d      = widx_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    wdata_d     = wdata_q;
    acc_d       = acc_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          k_d     = '0;
          wdata_d = write_bytes_i;
          if (brb_op_e'(opcode_i) == OP_WRITE) begin
            acc_d   = fits;
            cnt_d   = '0;
            if (fits && (len_sat != '0)) begin
              cnt_d   = len_sat;
              state_d = ST_WRITE;
            end else begin
              state_d = ST_DONE;
            end
          end else begin
            acc_d = 1'b0;
            cnt_d = rd_n;
            state_d = (rd_n != '0) ? ST_READ : ST_DONE;
          end
        end
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        widx_d = idx_inc(widx_q);
        k_d    = k_q + 1'b1;
        if (k_q == cnt_q - 1'b1) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        mem_re = 1'b1;
        ridx_d = idx_inc(ridx_q);
        k_d    = k_q + 1'b1;
        if (k_q == cnt_q - 1'b1) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the last read byte lands and the output slot is free
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ridx_q      <= '0;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ridx_q      <= ridx_d;
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
      rd_pend_q   <= mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    k_q      <= k_d;
    wdata_q  <= wdata_d;
    acc_q    <= acc_d;
    rd_pos_q <= k_q[ByteIdxW-1:0];
    if (in_fire) begin
      rdata_q <= '0;
    end else if (rd_pend_q) begin
      rdata_q[rd_pos_q*ByteW +: ByteW] <= mem_rdata;
    end
    if (out_load) begin
      out_acc_q  <= acc_q;
      // a stored write carries its length in cnt_q; report no read count
      out_cnt_q  <= acc_q ? '0 : cnt_q;
      out_data_q <= rdata_q;
    end
  end

  brb_ram #(
    .Depth (STORE_BYTES),
    .AddrW (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (widx_q),
    .wdata_i (wdata_q[k_q[ByteIdxW-1:0]*ByteW +: ByteW]),
    .re_i    (mem_re),
    .raddr_i (ridx_q),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign write_accepted_o = out_acc_q;
  assign read_count_o     = out_cnt_q;
  assign read_bytes_o     = out_data_q;

endmodule

// File: hdl/brb_ram.sv
// Simple dual-port byte memory, one write and one read port, registered read.
// Depends on brb_pkg for the byte width.
module brb_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [brb_pkg::ByteW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [brb_pkg::ByteW-1:0] rdata_o
);
  import brb_pkg::*;

  logic [ByteW-1:0] mem_q [Depth];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
